### rtl/cpg_pkg.sv
// ----------------------------------------------------------------------------
// cpg_pkg
// shared types and constants of the circle point generator
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int CENTER_W    = 12;
  localparam int COORD_W     = 13;
  localparam int OCT_X_W     = RADIUS_BITS + 1;
  localparam int OCT_Y_W     = RADIUS_BITS + 1;
  localparam int DEC_W       = RADIUS_BITS + 6;
  localparam int CFG_DATA_W  = (RADIUS_BITS > CENTER_W) ? RADIUS_BITS : CENTER_W;
  localparam int CFG_IDX_W   = 2;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int PT_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

  localparam logic [PT_IDX_W-1:0] PT_FIRST = 3'd0;
  localparam logic [PT_IDX_W-1:0] PT_LAST  = 3'd7;

  localparam int DEC_INIT     = 3;
  localparam int DEC_STEP_IN  = 6;
  localparam int DEC_STEP_OUT = 10;

  typedef struct packed {
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic                   done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/cpg_in_if.sv
// ----------------------------------------------------------------------------
// cpg_in_if
// step tick channel: valid, ready and the restart flag
// ----------------------------------------------------------------------------
interface cpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

### rtl/cpg_out_if.sv
// ----------------------------------------------------------------------------
// cpg_out_if
// result channel: one point or one done marker per item
// ----------------------------------------------------------------------------
interface cpg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cpg_pkg::COORD_W-1:0] point_x;
  logic signed [cpg_pkg::COORD_W-1:0] point_y;
  logic                               last_point;
  logic                               done_res;

  modport source (output valid, output point_x, output point_y, output last_point,
                  output done_res, input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                input done_res, output ready);
endinterface

### rtl/cpg_walker.sv
// ----------------------------------------------------------------------------
// cpg_walker
// front end: takes step ticks, walks the octant and queues one command each
// ----------------------------------------------------------------------------
module cpg_walker (
  input  logic                            clk,
  input  logic                            rst_n,
  cpg_in_if.sink                          in_if,
  input  logic [cpg_pkg::RADIUS_BITS-1:0] radius,
  input  cpg_pkg::q_stat_t                q_stat,
  output logic                            push,
  output cpg_pkg::cmd_t                   push_cmd
);

  localparam int XW = cpg_pkg::OCT_X_W;
  localparam int YW = cpg_pkg::OCT_Y_W;
  localparam int DW = cpg_pkg::DEC_W;
  localparam int RB = cpg_pkg::RADIUS_BITS;

  logic        [XW-1:0] x_r, x_nxt;
  logic signed [YW-1:0] y_r, y_nxt;
  logic signed [DW-1:0] d_r, d_nxt;

  logic        [XW-1:0] xs, x_inc;
  logic signed [YW-1:0] ys;
  logic signed [DW-1:0] ds, r_d, x1_d, y_d;
  logic                 fin;

  assign in_if.ready = !q_stat.full;
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    r_d = signed'(DW'(radius));
    if (in_if.restart) begin
      xs = '0;
      ys = signed'(YW'(radius));
      ds = DW'(cpg_pkg::DEC_INIT) - (r_d <<< 1);
    end else begin
      xs = x_r;
      ys = y_r;
      ds = d_r;
    end
    fin   = signed'({1'b0, xs}) > (YW + 1)'(ys);
    x_inc = xs + XW'(1);
    x1_d  = signed'(DW'(x_inc));
    y_d   = DW'(ys);

    push_cmd.x    = xs[RB-1:0];
    push_cmd.y    = ys[RB-1:0];
    push_cmd.done = fin;

    x_nxt = xs;
    y_nxt = ys;
    d_nxt = ds;
    if (!fin) begin
      x_nxt = x_inc;
      if (ds < 0) begin
        d_nxt = ds + (x1_d <<< 2) + DW'(cpg_pkg::DEC_STEP_IN);
      end else begin
        d_nxt = ds + ((x1_d - y_d) <<< 2) + DW'(cpg_pkg::DEC_STEP_OUT);
        y_nxt = ys - YW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '1;
      d_r <= '0;
    end else if (push) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      d_r <= d_nxt;
    end
  end

endmodule

### rtl/cpg_queue.sv
// ----------------------------------------------------------------------------
// cpg_queue
// short command queue between the walker and the point emitter
// ----------------------------------------------------------------------------
module cpg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cpg_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output cpg_pkg::cmd_t     head,
  output cpg_pkg::q_stat_t  q_stat
);

  localparam int PW = cpg_pkg::Q_PTR_W;
  localparam int CW = cpg_pkg::Q_CNT_W;

  cpg_pkg::cmd_t   mem_r [cpg_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign head         = mem_r[rd_r];
  assign q_stat.full  = (cnt_r == CW'(cpg_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(cpg_pkg::Q_DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(cpg_pkg::Q_DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

### rtl/cpg_emitter.sv
// ----------------------------------------------------------------------------
// cpg_emitter
// back end: turns each command into eight symmetric points or a done marker
// ----------------------------------------------------------------------------
module cpg_emitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cpg_pkg::cmd_t                       head,
  input  cpg_pkg::q_stat_t                    q_stat,
  input  logic signed [cpg_pkg::CENTER_W-1:0] center_x,
  input  logic signed [cpg_pkg::CENTER_W-1:0] center_y,
  output logic                                pop,
  cpg_out_if.source                           out_if
);

  localparam int CW = cpg_pkg::COORD_W;
  localparam int KW = cpg_pkg::PT_IDX_W;

  logic [KW-1:0]        k_r, k_nxt;
  logic                 vld_r, vld_nxt;
  logic signed [CW-1:0] px_r, py_r, px_nxt, py_nxt;
  logic                 last_r, done_r, last_nxt, done_nxt;

  logic                 load;
  logic signed [CW-1:0] cx, cy, a, b;

  assign load = !q_stat.empty && (!vld_r || out_if.ready);
  assign pop  = load && (head.done || (k_r == cpg_pkg::PT_LAST));

  always_comb begin
    cx = CW'(center_x);
    cy = CW'(center_y);
    // swap x and y for the second half of the octant set
    a  = k_r[2] ? signed'(CW'(head.y)) : signed'(CW'(head.x));
    b  = k_r[2] ? signed'(CW'(head.x)) : signed'(CW'(head.y));
    if (head.done) begin
      px_nxt   = '0;
      py_nxt   = '0;
      last_nxt = 1'b1;
      done_nxt = 1'b1;
    end else begin
      px_nxt   = k_r[0] ? cx - a : cx + a;
      py_nxt   = k_r[1] ? cy - b : cy + b;
      last_nxt = (k_r == cpg_pkg::PT_LAST);
      done_nxt = 1'b0;
    end
    k_nxt   = pop ? cpg_pkg::PT_FIRST : (load ? k_r + KW'(1) : k_r);
    vld_nxt = load ? 1'b1 : (out_if.ready ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= cpg_pkg::PT_FIRST;
      vld_r <= 1'b0;
    end else begin
      k_r   <= k_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      last_r <= last_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_if.valid      = vld_r;
  assign out_if.point_x    = px_r;
  assign out_if.point_y    = py_r;
  assign out_if.last_point = last_r;
  assign out_if.done_res   = done_r;

endmodule

### rtl/circle_point_generator.sv
// ----------------------------------------------------------------------------
// circle_point_generator
// midpoint circle rasterizer with configurable center and radius
// ----------------------------------------------------------------------------
// Each step tick yields the eight symmetric points of the current octant
// position, one per cycle on the result channel while it is ready, or a
// single done marker once the octant is finished. The walker accepts ticks
// into a two-entry command queue whose head is the tick being emitted, so
// one tick is taken ahead of the emitter; an accepted tick is written into
// the queue first and then into the output register before its first item
// is valid. The radius is used at restart only; the center is applied as
// each point is emitted.
module circle_point_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  cpg_in_if.sink                            in_if,
  cpg_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [cpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic signed [cpg_pkg::CENTER_W-1:0] center_x_r, center_y_r;
  logic [cpg_pkg::RADIUS_BITS-1:0]     radius_r;

  logic             push, pop;
  cpg_pkg::cmd_t    push_cmd, head;
  cpg_pkg::q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpg_pkg::CFG_CENTER_X: center_x_r <= signed'(cfg_data[cpg_pkg::CENTER_W-1:0]);
        cpg_pkg::CFG_CENTER_Y: center_y_r <= signed'(cfg_data[cpg_pkg::CENTER_W-1:0]);
        cpg_pkg::CFG_RADIUS:   radius_r   <= cfg_data[cpg_pkg::RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  cpg_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .radius   (radius_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cpg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  cpg_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule
